// File: hw/rtl/gsde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsde_pkg
// Shared widths, constants, register indexes and types for the gamepad stick
// deadzone and button edge block.
// ----------------------------------------------------------------------------
package gsde_pkg;

    localparam int PLAYER_W  = 2;
    localparam int BUTTON_W  = 16;
    localparam int AXIS_W    = 16;
    localparam int MAG_W     = AXIS_W - 1;
    localparam int TRIG_W    = 8;
    localparam int FACE_W    = 4;
    localparam int FACE_SHIFT = 12;
    localparam int DZ_W      = 14;
    localparam int GAIN_W    = 18;
    localparam int GAIN_FRAC = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = GAIN_W;
    localparam int PLAYERS_W = 3;

    localparam logic [MAG_W-1:0] AXIS_FULL = 15'd32767;

    localparam logic [PLAYERS_W-1:0] PLAYERS_RESET = 3'd1;
    localparam logic [DZ_W-1:0]      DZ_X_RESET    = 14'd1638;
    localparam logic [DZ_W-1:0]      DZ_Y_RESET    = 14'd655;
    localparam logic [GAIN_W-1:0]    GAIN_X_RESET  = 18'd68985;
    localparam logic [GAIN_W-1:0]    GAIN_Y_RESET  = 18'd66873;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE         = 3'd0,
        REG_PLAYERS_IN_USE = 3'd1,
        REG_DEADZONE_X     = 3'd2,
        REG_DEADZONE_Y     = 3'd3,
        REG_GAIN_X         = 3'd4,
        REG_GAIN_Y         = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [FACE_W-1:0] pressed;
        logic [FACE_W-1:0] released;
    } face_edges_t;

endpackage

// File: hw/rtl/gsde_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsde_sample_if
// Valid/ready channel carrying one raw controller sample per item.
// ----------------------------------------------------------------------------
interface gsde_sample_if;
    import gsde_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PLAYER_W-1:0]        player;
    logic [BUTTON_W-1:0]        button_word;
    logic signed [AXIS_W-1:0]   left_x_raw;
    logic signed [AXIS_W-1:0]   left_y_raw;
    logic signed [AXIS_W-1:0]   right_x_raw;
    logic signed [AXIS_W-1:0]   right_y_raw;
    logic [TRIG_W-1:0]          left_trigger_raw;
    logic [TRIG_W-1:0]          right_trigger_raw;

    modport source (
        output valid, player, button_word, left_x_raw, left_y_raw,
               right_x_raw, right_y_raw, left_trigger_raw, right_trigger_raw,
        input  ready
    );

    modport sink (
        input  valid, player, button_word, left_x_raw, left_y_raw,
               right_x_raw, right_y_raw, left_trigger_raw, right_trigger_raw,
        output ready
    );
endinterface

// File: hw/rtl/gsde_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsde_result_if
// Valid/ready channel carrying one conditioned controller result per item.
// ----------------------------------------------------------------------------
interface gsde_result_if;
    import gsde_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PLAYER_W-1:0]        player_out;
    logic [BUTTON_W-1:0]        held_buttons;
    logic [FACE_W-1:0]          pressed_edges;
    logic [FACE_W-1:0]          released_edges;
    logic signed [AXIS_W-1:0]   left_x;
    logic signed [AXIS_W-1:0]   left_y;
    logic signed [AXIS_W-1:0]   right_x;
    logic signed [AXIS_W-1:0]   right_y;
    logic [TRIG_W-1:0]          left_trigger;
    logic [TRIG_W-1:0]          right_trigger;

    modport source (
        output valid, player_out, held_buttons, pressed_edges, released_edges,
               left_x, left_y, right_x, right_y, left_trigger, right_trigger,
        input  ready
    );

    modport sink (
        input  valid, player_out, held_buttons, pressed_edges, released_edges,
               left_x, left_y, right_x, right_y, left_trigger, right_trigger,
        output ready
    );
endinterface

// File: hw/rtl/gsde_axis_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsde_axis_shaper
// One stick axis: clamp, deadzone, Q16 rescale with round half up,
// saturation and sign restore.
// ----------------------------------------------------------------------------
module gsde_axis_shaper
    import gsde_pkg::*;
(
    input  logic signed [AXIS_W-1:0] raw,
    input  logic [DZ_W-1:0]          deadzone,
    input  logic [GAIN_W-1:0]        gain,
    output logic signed [AXIS_W-1:0] shaped
);

    localparam int PROD_W = MAG_W + GAIN_W;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (GAIN_FRAC - 1);

    logic                neg;
    logic [AXIS_W-1:0]   abs_val;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    dz_ext;
    logic [MAG_W-1:0]    excess;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     rounded;
    logic [MAG_W-1:0]    level;
    logic [AXIS_W-1:0]   out_mag;

    always_comb
    begin
        neg     = raw[AXIS_W-1];
        abs_val = neg ? (~unsigned'(raw) + AXIS_W'(1)) : unsigned'(raw);
        // the most negative reading folds onto full scale
        mag     = abs_val[AXIS_W-1] ? AXIS_FULL : abs_val[MAG_W-1:0];
        dz_ext  = MAG_W'(deadzone);
        excess  = mag - dz_ext;
        prod    = PROD_W'(excess) * PROD_W'(gain);
        rounded = {1'b0, prod} + ROUND_HALF;
        if (|rounded[PROD_W:GAIN_FRAC+MAG_W])
        begin
            level = AXIS_FULL;
        end
        else
        begin
            level = rounded[GAIN_FRAC+MAG_W-1:GAIN_FRAC];
        end
        out_mag = {1'b0, level};
        if (mag < dz_ext)
        begin
            shaped = '0;
        end
        else
        begin
            shaped = neg ? signed'(~out_mag + AXIS_W'(1)) : signed'(out_mag);
        end
    end

endmodule

// File: hw/rtl/gsde_face_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsde_face_tracker
// Per-player store of the last A, B, X, Y levels; gives press and release
// edges for the incoming item and updates the store when update is asserted.
// ----------------------------------------------------------------------------
module gsde_face_tracker
    import gsde_pkg::*;
#(
    parameter int PLAYER_COUNT = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  logic [PLAYER_W-1:0] player,
    input  logic [FACE_W-1:0]   face,
    output face_edges_t         edges
);

    localparam int IDX_W = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;

    logic [FACE_W-1:0] prev_reg [PLAYER_COUNT];
    logic [IDX_W-1:0]  idx;
    logic [FACE_W-1:0] prev;

    assign idx  = IDX_W'(player);
    assign prev = prev_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAYER_COUNT; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (update)
        begin
            prev_reg[idx] <= face;
        end
    end

    always_comb
    begin
        edges.pressed  = face & ~prev;
        edges.released = prev & ~face;
    end

endmodule

// File: hw/rtl/gamepad_stick_deadzone_and_edges.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_stick_deadzone_and_edges
// Controller sample conditioning: stick deadzone and rescale, trigger
// pass-through, face button press/release edges per player.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the result register drains, and
// hands back one result per kept sample: the sample is registered on entry
// (face button edges are resolved against the per-player store there), and
// the four axis shapers, each one 15x18 multiply with round and saturate,
// feed the result register. Samples taken while disabled, or for a player at
// or beyond players_in_use or PLAYER_COUNT, are consumed without a result and
// leave the button store untouched. A waiting result blocks entry once the
// input register is full, which then takes items only while the result
// register drains. Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module gamepad_stick_deadzone_and_edges
    import gsde_pkg::*;
#(
    parameter int PLAYER_COUNT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    gsde_sample_if.sink          sample,
    gsde_result_if.source        result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic                 enable_reg;
    logic [PLAYERS_W-1:0] players_reg;
    logic [DZ_W-1:0]      dz_x_reg;
    logic [DZ_W-1:0]      dz_y_reg;
    logic [GAIN_W-1:0]    gain_x_reg;
    logic [GAIN_W-1:0]    gain_y_reg;

    // input stage
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [PLAYER_W-1:0]      s1_player_reg;
    logic [BUTTON_W-1:0]      s1_buttons_reg;
    face_edges_t              s1_edges_reg;
    logic signed [AXIS_W-1:0] s1_lx_reg;
    logic signed [AXIS_W-1:0] s1_ly_reg;
    logic signed [AXIS_W-1:0] s1_rx_reg;
    logic signed [AXIS_W-1:0] s1_ry_reg;
    logic [TRIG_W-1:0]        s1_lt_reg;
    logic [TRIG_W-1:0]        s1_rt_reg;

    // result stage
    logic                     out_valid_reg;
    logic [PLAYER_W-1:0]      out_player_reg;
    logic [BUTTON_W-1:0]      out_buttons_reg;
    face_edges_t              out_edges_reg;
    logic signed [AXIS_W-1:0] out_lx_reg;
    logic signed [AXIS_W-1:0] out_ly_reg;
    logic signed [AXIS_W-1:0] out_rx_reg;
    logic signed [AXIS_W-1:0] out_ry_reg;
    logic [TRIG_W-1:0]        out_lt_reg;
    logic [TRIG_W-1:0]        out_rt_reg;

    logic                     out_advance;
    logic                     s1_advance;
    logic                     take;
    logic                     keep;
    face_edges_t              in_edges;
    logic signed [AXIS_W-1:0] lx_shaped;
    logic signed [AXIS_W-1:0] ly_shaped;
    logic signed [AXIS_W-1:0] rx_shaped;
    logic signed [AXIS_W-1:0] ry_shaped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            players_reg <= PLAYERS_RESET;
            dz_x_reg    <= DZ_X_RESET;
            dz_y_reg    <= DZ_Y_RESET;
            gain_x_reg  <= GAIN_X_RESET;
            gain_y_reg  <= GAIN_Y_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ENABLE:         enable_reg  <= cfg_data[0];
                REG_PLAYERS_IN_USE: players_reg <= cfg_data[PLAYERS_W-1:0];
                REG_DEADZONE_X:     dz_x_reg    <= cfg_data[DZ_W-1:0];
                REG_DEADZONE_Y:     dz_y_reg    <= cfg_data[DZ_W-1:0];
                REG_GAIN_X:         gain_x_reg  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:         gain_y_reg  <= cfg_data[GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign out_advance  = !out_valid_reg || result.ready;
    assign s1_advance   = !s1_valid_reg || out_advance;
    assign sample.ready = s1_advance;
    assign take         = sample.valid && s1_advance;
    // drop items while disabled or for players at or beyond the count in use or PLAYER_COUNT
    assign keep = take && enable_reg
                  && ({1'b0, sample.player} < players_reg)
                  && (32'(sample.player) < PLAYER_COUNT);
    assign s1_valid_next = s1_advance ? keep : s1_valid_reg;

    gsde_face_tracker #(
        .PLAYER_COUNT (PLAYER_COUNT)
    ) u_face_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (keep),
        .player (sample.player),
        .face   (sample.button_word[FACE_SHIFT +: FACE_W]),
        .edges  (in_edges)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            s1_player_reg  <= sample.player;
            s1_buttons_reg <= sample.button_word;
            s1_edges_reg   <= in_edges;
            s1_lx_reg      <= sample.left_x_raw;
            s1_ly_reg      <= sample.left_y_raw;
            s1_rx_reg      <= sample.right_x_raw;
            s1_ry_reg      <= sample.right_y_raw;
            s1_lt_reg      <= sample.left_trigger_raw;
            s1_rt_reg      <= sample.right_trigger_raw;
        end
    end

    gsde_axis_shaper u_shape_lx (
        .raw (s1_lx_reg), .deadzone (dz_x_reg), .gain (gain_x_reg), .shaped (lx_shaped)
    );
    gsde_axis_shaper u_shape_ly (
        .raw (s1_ly_reg), .deadzone (dz_y_reg), .gain (gain_y_reg), .shaped (ly_shaped)
    );
    gsde_axis_shaper u_shape_rx (
        .raw (s1_rx_reg), .deadzone (dz_x_reg), .gain (gain_x_reg), .shaped (rx_shaped)
    );
    gsde_axis_shaper u_shape_ry (
        .raw (s1_ry_reg), .deadzone (dz_y_reg), .gain (gain_y_reg), .shaped (ry_shaped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            out_player_reg  <= s1_player_reg;
            out_buttons_reg <= s1_buttons_reg;
            out_edges_reg   <= s1_edges_reg;
            out_lx_reg      <= lx_shaped;
            out_ly_reg      <= ly_shaped;
            out_rx_reg      <= rx_shaped;
            out_ry_reg      <= ry_shaped;
            out_lt_reg      <= s1_lt_reg;
            out_rt_reg      <= s1_rt_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.player_out     = out_player_reg;
    assign result.held_buttons   = out_buttons_reg;
    assign result.pressed_edges  = out_edges_reg.pressed;
    assign result.released_edges = out_edges_reg.released;
    assign result.left_x         = out_lx_reg;
    assign result.left_y         = out_ly_reg;
    assign result.right_x        = out_rx_reg;
    assign result.right_y        = out_ry_reg;
    assign result.left_trigger   = out_lt_reg;
    assign result.right_trigger  = out_rt_reg;

    // a kept item always lands in the input stage
    a_keep_loads: assert property (@(posedge clk) disable iff (!rst_n)
        keep |=> s1_valid_reg)
        else $error("kept item did not reach the input stage");

    // a button cannot be pressed and released in the same result
    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_edges_reg.pressed & out_edges_reg.released) == '0))
        else $error("press and release edge on the same button");

    // shaped axes stay within +-32767
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_lx_reg != 16'sh8000) && (out_ly_reg != 16'sh8000)
                          && (out_rx_reg != 16'sh8000) && (out_ry_reg != 16'sh8000))
        else $error("axis result outside full scale");

endmodule
